// ===== rtl/core/mpi_pkg.sv =====
// Shared types, constants and helpers for the escape-time pixel unit.
// Depends on nothing; every other file imports it.
package mpi_pkg;

	// image size, fixed at build time; both sizes are powers of two
	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	localparam int PIX_W   = 10;
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 27;
	localparam int CNT_W   = 16;
	localparam int SPAN_W  = COORD_W + 1;
	localparam int PROD_W  = PIX_W + SPAN_W;
	localparam int MAG_W   = PROD_W - 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SIZE_W  = 13;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int SHAMT_W = $clog2(SIZE_W);
	// dividing by a power-of-two size is a right shift of the magnitude
	localparam int WIDTH_SHIFT  = $clog2(IMAGE_WIDTH);
	localparam int HEIGHT_SHIFT = $clog2(IMAGE_HEIGHT);

	// 4.0 in the Q10.54 format of the squares
	localparam logic [SQ_W-1:0] ESCAPE_BOUND = SQ_W'(1) << (2 * FRAC_W + 2);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	// front stage, queue, back stage and output register
	localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

	localparam int S_TDATA_W = ((2 * PIX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * PIX_W + CNT_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [COORD_W-1:0] RESET_REAL_MIN = -32'sd268435456;
	localparam logic signed [COORD_W-1:0] RESET_REAL_MAX = 32'sd268435456;
	localparam logic signed [COORD_W-1:0] RESET_IMAG_MIN = -32'sd268435456;
	localparam logic signed [COORD_W-1:0] RESET_IMAG_MAX = 32'sd268435456;
	localparam logic [CNT_W-1:0]          RESET_ITER_LIMIT = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REAL_MIN,
		REG_REAL_MAX,
		REG_IMAG_MIN,
		REG_IMAG_MAX,
		REG_SHIFT_REAL,
		REG_SHIFT_IMAG,
		REG_ITER_LIMIT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] real_min;
		logic signed [COORD_W-1:0] real_max;
		logic signed [COORD_W-1:0] imag_min;
		logic signed [COORD_W-1:0] imag_max;
		logic signed [COORD_W-1:0] shift_real;
		logic signed [COORD_W-1:0] shift_imag;
		logic [CNT_W-1:0]          iteration_limit;
	} cfg_t;

	// one mapped pixel, handed from the front to the back
	typedef struct packed {
		logic signed [COORD_W-1:0] c_re;
		logic signed [COORD_W-1:0] c_im;
		logic [PIX_W-1:0]          col;
		logic [PIX_W-1:0]          row;
	} point_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_MUL,
		FR_START,
		FR_SUM,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_UPD,
		BK_DONE
	} back_state_t;

	// clamp a wide signed value into the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
			return v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== rtl/core/mpi_cdiv.sv =====
// Divider of an unsigned magnitude by the power-of-two image size: one registered shift.
// Depends on mpi_pkg for widths.
module mpi_cdiv import mpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MAG_W-1:0]   dividend,
	input  logic [SHAMT_W-1:0] shamt,
	output logic [MAG_W-1:0]   quotient
);

	logic [MAG_W-1:0] quot_q;

	// shift amount is tied to a constant, so the shift is plain wiring ahead of the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
		end else if (start) begin
			quot_q <= dividend >> shamt;
		end
	end

	assign quotient = quot_q;

endmodule

// ===== rtl/core/mpi_front.sv =====
// Front end: accepts a pixel and maps it to the point c of the complex plane.
// Depends on mpi_pkg and mpi_cdiv.
module mpi_front import mpi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] in_col,
	input  logic [PIX_W-1:0] in_row,
	output logic             push,
	output point_t           push_data,
	input  logic             q_full
);

	front_state_t state_q, state_d;

	logic [PIX_W-1:0]         col_q, row_q;
	logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
	logic                     neg_re_q, neg_im_q;
	logic signed [COORD_W-1:0] c_re_q, c_im_q;

	logic mul_en, div_start, sum_en;

	logic signed [PROD_W-1:0] col_w, row_w, span_re, span_im;
	logic signed [PROD_W-1:0] prod_re, prod_im, abs_re, abs_im;
	logic [MAG_W-1:0]         quot_re, quot_im;
	logic signed [PROD_W-1:0] q_re, q_im;
	logic signed [SUM_W-1:0]  sum_re, sum_im;

	// span is exact in 33 bits; the product fits PROD_W
	assign col_w   = PROD_W'(signed'({1'b0, col_q}));
	assign row_w   = PROD_W'(signed'({1'b0, row_q}));
	assign span_re = PROD_W'(cfg.real_max) - PROD_W'(cfg.real_min);
	assign span_im = PROD_W'(cfg.imag_max) - PROD_W'(cfg.imag_min);
	assign prod_re = col_w * span_re;
	assign prod_im = row_w * span_im;

	assign abs_re = prod_re_q[PROD_W-1] ? -prod_re_q : prod_re_q;
	assign abs_im = prod_im_q[PROD_W-1] ? -prod_im_q : prod_im_q;

	mpi_cdiv u_div_re (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_re[MAG_W-1:0]),
		.shamt    (SHAMT_W'(WIDTH_SHIFT)),
		.quotient (quot_re)
	);

	mpi_cdiv u_div_im (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_im[MAG_W-1:0]),
		.shamt    (SHAMT_W'(HEIGHT_SHIFT)),
		.quotient (quot_im)
	);

	// restore the sign: truncation toward zero
	assign q_re = neg_re_q ? -PROD_W'(signed'({1'b0, quot_re})) : PROD_W'(signed'({1'b0, quot_re}));
	assign q_im = neg_im_q ? -PROD_W'(signed'({1'b0, quot_im})) : PROD_W'(signed'({1'b0, quot_im}));

	assign sum_re = SUM_W'(cfg.real_min) + SUM_W'(q_re) + SUM_W'(cfg.shift_real);
	assign sum_im = SUM_W'(cfg.imag_min) + SUM_W'(q_im) + SUM_W'(cfg.shift_imag);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE:  if (in_valid) state_d = FR_MUL;
			FR_MUL:   state_d = FR_START;
			FR_START: state_d = FR_SUM;
			FR_SUM:   state_d = FR_PUSH;
			FR_PUSH:  if (!q_full) state_d = FR_IDLE;
			default:  state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		sum_en    = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			FR_IDLE:  in_ready  = 1'b1;
			FR_MUL:   mul_en    = 1'b1;
			FR_START: div_start = 1'b1;
			FR_SUM:   sum_en    = 1'b1;
			FR_PUSH:  push      = !q_full;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			col_q <= in_col;
			row_q <= in_row;
		end
		if (mul_en) begin
			prod_re_q <= prod_re;
			prod_im_q <= prod_im;
		end
		if (div_start) begin
			neg_re_q <= prod_re_q[PROD_W-1];
			neg_im_q <= prod_im_q[PROD_W-1];
		end
		if (sum_en) begin
			c_re_q <= sat_coord(sum_re);
			c_im_q <= sat_coord(sum_im);
		end
	end

	assign push_data.c_re = c_re_q;
	assign push_data.c_im = c_im_q;
	assign push_data.col  = col_q;
	assign push_data.row  = row_q;

endmodule

// ===== rtl/core/mpi_queue.sv =====
// Short FIFO of mapped points between the front and back ends.
// Depends on mpi_pkg.
module mpi_queue import mpi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  point_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   pop_valid,
	output point_t pop_data
);

	point_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/mpi_back.sv =====
// Back end: runs z = z*z + c for one point and holds the result for transfer.
// Depends on mpi_pkg.
module mpi_back import mpi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] iter_limit,
	input  logic             q_valid,
	input  point_t           q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_col,
	output logic [PIX_W-1:0] out_row,
	output logic [CNT_W-1:0] out_count
);

	back_state_t state_q, state_d;

	logic signed [COORD_W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic [PIX_W-1:0]          col_q, row_q;
	logic [CNT_W-1:0]          n_q;
	logic signed [SQ_W-1:0]    zr2_s1, zi2_s1, zri_s1;

	logic                      out_valid_q;
	logic [PIX_W-1:0]          out_col_q, out_row_q;
	logic [CNT_W-1:0]          out_count_q;

	logic mul_en, step, load_out, out_free, escape, at_limit;
	logic signed [SQ_W-1:0]    zr_w, zi_w, diff, re_sh, im_sh;
	logic [SQ_W-1:0]           mag2;
	logic signed [COORD_W-1:0] nzr, nzi;

	assign zr_w = SQ_W'(zr_q);
	assign zi_w = SQ_W'(zi_q);

	// both squares are non-negative and at most 2^62, so the sum fits
	assign mag2     = zr2_s1 + zi2_s1;
	assign escape   = mag2 > ESCAPE_BOUND;
	assign at_limit = n_q == iter_limit;

	assign diff  = zr2_s1 - zi2_s1;
	assign re_sh = diff >>> FRAC_W;
	assign im_sh = zri_s1 >>> (FRAC_W - 1);
	assign nzr   = sat_coord(SUM_W'(re_sh) + SUM_W'(cr_q));
	assign nzi   = sat_coord(SUM_W'(im_sh) + SUM_W'(ci_q));

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) state_d = BK_MUL;
			BK_MUL:  state_d = at_limit ? BK_DONE : BK_UPD;
			BK_UPD:  state_d = escape ? BK_DONE : BK_MUL;
			BK_DONE: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		mul_en   = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: q_pop    = q_valid;
			BK_MUL:  mul_en   = !at_limit;
			BK_UPD:  step     = !escape;
			BK_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			zr_q  <= '0;
			zi_q  <= '0;
			n_q   <= '0;
			cr_q  <= q_data.c_re;
			ci_q  <= q_data.c_im;
			col_q <= q_data.col;
			row_q <= q_data.row;
		end else if (step) begin
			zr_q <= nzr;
			zi_q <= nzi;
			n_q  <= n_q + 1'b1;
		end
		if (mul_en) begin
			zr2_s1 <= zr_w * zr_w;
			zi2_s1 <= zi_w * zi_w;
			zri_s1 <= zr_w * zi_w;
		end
		if (load_out) begin
			out_col_q   <= col_q;
			out_row_q   <= row_q;
			out_count_q <= n_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign out_count = out_count_q;

endmodule

// ===== rtl/core/mandelbrot_pixel_iteration_unit.sv =====
// Escape-time pixel unit. Each pixel (column, row) is mapped to c =
// min + coord * (max - min) / size + shift, then z = z*z + c is iterated from
// zero until |z|^2 exceeds 4.0 or the iteration limit is reached. The front
// end maps a pixel in order (accept, span product, shift by the power-of-two
// image size, add with saturation, push) and takes no new pixel until it has
// pushed the last; a two-entry queue lets it run ahead of the back end. Each
// back-end iteration forms the registered 32x32 products, then does the escape
// test and update; that loop, with the pop of a point and the hand-off of its
// result, sets the sustained rate. The user must write registers only while the
// unit is idle; the unit itself does not enforce this. Writes to index 7 are ignored.
// Depends on mpi_pkg, mpi_front, mpi_queue and mpi_back.
module mandelbrot_pixel_iteration_unit import mpi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pixel_col, pixel_row, zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // out_col, out_row, escape_count, zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	logic   push, q_full, q_pop, q_valid;
	point_t push_data, q_data;

	logic [PIX_W-1:0] out_col, out_row;
	logic [CNT_W-1:0] out_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_min        <= RESET_REAL_MIN;
			cfg_q.real_max        <= RESET_REAL_MAX;
			cfg_q.imag_min        <= RESET_IMAG_MIN;
			cfg_q.imag_max        <= RESET_IMAG_MAX;
			cfg_q.shift_real      <= '0;
			cfg_q.shift_imag      <= '0;
			cfg_q.iteration_limit <= RESET_ITER_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REAL_MIN:   cfg_q.real_min        <= cfg_data;
				REG_REAL_MAX:   cfg_q.real_max        <= cfg_data;
				REG_IMAG_MIN:   cfg_q.imag_min        <= cfg_data;
				REG_IMAG_MAX:   cfg_q.imag_max        <= cfg_data;
				REG_SHIFT_REAL: cfg_q.shift_real      <= cfg_data;
				REG_SHIFT_IMAG: cfg_q.shift_imag      <= cfg_data;
				REG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data[CNT_W-1:0];
				default:        ;
			endcase
		end
	end

	mpi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_col    (s_axis_tdata[PIX_W-1:0]),
		.in_row    (s_axis_tdata[2*PIX_W-1:PIX_W]),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	mpi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	mpi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.iter_limit (cfg_q.iteration_limit),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_count  (out_count)
	);

	assign m_axis_tdata = M_TDATA_W'({out_count, out_row, out_col});

endmodule

// ===== rtl/core/mpi_checker.sv =====
// Port-level checks for the escape-time pixel unit, bound to the top level.
// Depends on mpi_pkg.
module mpi_checker import mpi_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [S_TDATA_W-1:0]  s_axis_tdata,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [M_TDATA_W-1:0]  m_axis_tdata,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int OUT_W = $clog2(MAX_INFLIGHT + 2);

	logic [OUT_W-1:0] pending_q;
	logic [CNT_W-1:0] limit_q;
	logic             s_xfer, m_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	// track accepted pixels not yet delivered, and the current limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			limit_q   <= RESET_ITER_LIMIT;
		end else begin
			if (s_xfer && !m_xfer) begin
				pending_q <= pending_q + 1'b1;
			end else if (m_xfer && !s_xfer) begin
				pending_q <= pending_q - 1'b1;
			end
			if (cfg_valid && cfg_ready && (cfg_index == REG_ITER_LIMIT)) begin
				limit_q <= cfg_data[CNT_W-1:0];
			end
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != '0)
		else $error("result offered with no pixel outstanding");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OUT_W'(MAX_INFLIGHT))
		else $error("more pixels in flight than the unit can hold");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2*PIX_W+CNT_W-1:2*PIX_W] <= limit_q)
		else $error("escape count above iteration limit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind mandelbrot_pixel_iteration_unit mpi_checker u_checker (.*);
